### src/stop_bit_integer_codec_macros.svh
// Assertion macros shared by the stop-bit integer codec.
`ifndef STOP_BIT_INTEGER_CODEC_MACROS_SVH
`define STOP_BIT_INTEGER_CODEC_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge and off during reset.
`define SBIC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge and off during reset.
`define SBIC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/sbic_pkg.sv
// Types, codes and constants shared by the stop-bit integer codec modules.
package sbic_pkg;

   // Most code bytes that one value may occupy, and the group count of a 64-bit word.
   localparam int MAX_CODE_BYTES = 10;
   localparam int GROUP_BITS     = 7;
   localparam int NUM_GROUPS     = 10;
   localparam int JOB_DEPTH      = 2;

   localparam logic       OP_ENCODE = 1'b0;
   localparam logic       OP_DECODE = 1'b1;

   localparam logic [1:0] WIDTH_16 = 2'd0;
   localparam logic [1:0] WIDTH_32 = 2'd1;
   localparam logic [1:0] WIDTH_64 = 2'd2;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_LIMIT     = 2'd1;
   localparam logic [1:0] STATUS_FORCED_NEG = 2'd2;

   localparam logic [1:0] CSR_WIDTH_CODE   = 2'd0;
   localparam logic [1:0] CSR_VALUE_SIGNED = 2'd1;
   localparam logic [1:0] CSR_BYTE_LIMIT   = 2'd2;

   localparam logic [7:0] STOP_FLAG = 8'h80;

   typedef struct packed {
      logic        opcode;
      logic [63:0] value_in;
      logic        forced_sign;
      logic [7:0]  code_byte_in;
   } req_type;

   typedef struct packed {
      logic [7:0]  code_byte_out;
      logic        last;
      logic [63:0] decoded_value;
      logic [3:0]  decoded_length;
      logic        forced_sign_seen;
      logic [1:0]  status;
   } rsp_type;

   typedef struct packed {
      logic [1:0] width_code;
      logic       value_signed;
      logic [3:0] byte_limit;
   } cfg_type;

   // One unit of work for the back end: either a finished single result or a
   // code word that is sent out as nbytes code bytes.
   typedef struct packed {
      logic        single;
      logic [63:0] word;
      logic [3:0]  nbytes;
      rsp_type     rsp;
   } job_type;

   function automatic logic [63:0] width_mask(input logic [1:0] code);
      logic [63:0] m;
      unique case (code)
         WIDTH_16: m = 64'h0000_0000_0000_FFFF;
         WIDTH_32: m = 64'h0000_0000_FFFF_FFFF;
         default:  m = '1;
      endcase
      return m;
   endfunction

endpackage

### src/sbic_front.sv
// Front end: classifies each item, prepares encode words and runs the decoder.
module sbic_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  sbic_pkg::req_type req,
   input  sbic_pkg::cfg_type cfg,
   output logic             job_push,
   output sbic_pkg::job_type job
);
   import sbic_pkg::*;

   logic [63:0] acc_ff, acc_in;
   logic [3:0]  count_ff, count_in;

   logic [63:0] mask;
   logic [63:0] v;
   logic        top_bit;
   logic        neg;
   logic [63:0] mag;
   logic [63:0] word;
   logic [69:0] word_pad;
   logic [3:0]  ngroups;
   logic [3:0]  limit;

   logic [6:0]  shamt;
   logic [63:0] grp_sh;
   logic [63:0] acc_new;
   logic [3:0]  count_next;
   logic [63:0] dmag;
   logic        dsign;
   logic        emit_job;
   job_type     job_w;

   always_comb begin
      mask = width_mask(cfg.width_code);
      if (cfg.byte_limit == 4'd0) begin
         limit = 4'd1;
      end else if (cfg.byte_limit > 4'(MAX_CODE_BYTES)) begin
         limit = 4'(MAX_CODE_BYTES);
      end else begin
         limit = cfg.byte_limit;
      end
   end

   // Encode path: sign-magnitude word and its group count.
   always_comb begin
      v = req.value_in & mask;
      unique case (cfg.width_code)
         WIDTH_16: top_bit = v[15];
         WIDTH_32: top_bit = v[31];
         default:  top_bit = v[63];
      endcase
      neg      = cfg.value_signed & top_bit;
      mag      = neg ? ((~v + 64'd1) & mask) : v;
      word     = ((mag << 1) & mask) | {63'd0, neg | req.forced_sign};
      word_pad = {6'd0, word};
      ngroups  = '0;
      for (int i = 0; i < NUM_GROUPS; i++) begin
         if (word_pad[i*GROUP_BITS +: GROUP_BITS] != '0) begin
            ngroups = 4'(i + 1);
         end
      end
   end

   // Decode path: groups never overlap earlier ones, so an OR does the add.
   always_comb begin
      shamt      = {count_ff, 3'd0} - {3'd0, count_ff};
      grp_sh     = {57'd0, req.code_byte_in[6:0]} << shamt;
      acc_new    = (acc_ff | grp_sh) & mask;
      count_next = count_ff + 4'd1;
      dsign      = acc_new[0];
      dmag       = acc_new >> 1;
   end

   always_comb begin
      job_w    = '0;
      emit_job = 1'b0;
      acc_in   = acc_ff;
      count_in = count_ff;
      if (req.opcode == OP_ENCODE) begin
         emit_job         = 1'b1;
         job_w.single     = 1'b1;
         job_w.rsp.last   = 1'b1;
         priority if (v == '0) begin
            job_w.rsp.code_byte_out = STOP_FLAG | {7'd0, req.forced_sign};
         end else if (neg && req.forced_sign) begin
            job_w.rsp.status = STATUS_FORCED_NEG;
         end else if (word == '0) begin
            job_w.rsp.code_byte_out = STOP_FLAG;
         end else if (ngroups > limit) begin
            job_w.rsp.status = STATUS_LIMIT;
         end else begin
            job_w.single = 1'b0;
            job_w.word   = word;
            job_w.nbytes = ngroups;
         end
      end else begin
         acc_in   = acc_new;
         count_in = count_next;
         if (req.code_byte_in[7]) begin
            emit_job                   = 1'b1;
            job_w.single               = 1'b1;
            job_w.rsp.last             = 1'b1;
            job_w.rsp.decoded_value    = (!req.forced_sign && dsign && dmag != '0)
                                         ? ((~dmag + 64'd1) & mask) : dmag;
            job_w.rsp.decoded_length   = count_next;
            job_w.rsp.forced_sign_seen = dsign & ((dmag == '0) | req.forced_sign);
            acc_in                     = '0;
            count_in                   = '0;
         end else if (count_next >= limit) begin
            emit_job         = 1'b1;
            job_w.single     = 1'b1;
            job_w.rsp.last   = 1'b1;
            job_w.rsp.status = STATUS_LIMIT;
            acc_in           = '0;
            count_in         = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         count_ff <= '0;
      end else if (accept) begin
         acc_ff   <= acc_in;
         count_ff <= count_in;
      end
   end

   assign job_push = accept & emit_job;
   assign job      = job_w;

endmodule

### src/sbic_queue.sv
// Short job queue between the front end and the back end.
module sbic_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  sbic_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output logic             valid,
   output sbic_pkg::job_type head
);
   import sbic_pkg::*;

   localparam int PtrBits   = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
   localparam int CountBits = $clog2(JOB_DEPTH + 1);

   job_type              entry_ff [JOB_DEPTH];
   logic [PtrBits-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CountBits-1:0] count_ff;

   function automatic logic [PtrBits-1:0] bump(input logic [PtrBits-1:0] p);
      return (p == PtrBits'(JOB_DEPTH - 1)) ? '0 : p + PtrBits'(1);
   endfunction

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= bump(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= bump(rd_ptr_ff);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CountBits'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CountBits'(1);
         end
      end
   end

   assign full  = (count_ff == CountBits'(JOB_DEPTH));
   assign valid = (count_ff != '0);
   assign head  = entry_ff[rd_ptr_ff];

endmodule

### src/sbic_back.sv
// Back end: turns jobs into result beats, one beat per cycle while the output register is free.
module sbic_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   input  sbic_pkg::job_type job,
   output logic             job_take,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output sbic_pkg::rsp_type rsp_data
);
   import sbic_pkg::*;

   logic    busy_ff;
   job_type cur_ff;
   logic    out_valid_ff;
   rsp_type out_ff;

   logic    out_free;
   logic    emit;
   logic    last_beat;
   rsp_type beat;

   always_comb begin
      out_free  = !out_valid_ff || rsp_pop;
      emit      = busy_ff && out_free;
      last_beat = cur_ff.single || (cur_ff.nbytes == 4'd1);
      job_take  = job_valid && (!busy_ff || (emit && last_beat));
      beat      = '0;
      if (cur_ff.single) begin
         beat = cur_ff.rsp;
      end else begin
         beat.code_byte_out = {last_beat, cur_ff.word[GROUP_BITS-1:0]};
         beat.last          = last_beat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (job_take) begin
            busy_ff <= 1'b1;
         end else if (emit && last_beat) begin
            busy_ff <= 1'b0;
         end
         if (emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (job_take) begin
         cur_ff <= job;
      end else if (emit) begin
         cur_ff.word   <= cur_ff.word >> GROUP_BITS;
         cur_ff.nbytes <= cur_ff.nbytes - 4'd1;
      end
      if (emit) begin
         out_ff <= beat;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

### src/stop_bit_integer_codec.sv
// Stop-bit integer codec top level: configuration registers, front end, job queue, back end.
//
// This block encodes integers into sign-magnitude stop-bit code bytes and decodes such
// bytes back into integers; the opcode of each input beat picks the direction. An encode
// beat yields one result beat per code byte (one to ten, the last one flagged), or a single
// status beat when the value is a forced-sign negative or needs more bytes than the limit.
// A decode beat carries one code byte; the block answers only on the byte with the stop bit
// set, or with a status beat when the byte limit runs out. The front end classifies each
// beat in the cycle it is accepted and keeps the decoder accumulator, so a decode stream
// is taken at one byte per cycle while the job queue has room. Work for the back end goes
// through a two-entry job queue; the back end sends one result beat per cycle into an output
// register while it is free, so a run of encodes, once the queue has filled, is taken only
// as fast as the back end drains it. Configuration writes take effect at once and must
// only be made while no results are outstanding.
module stop_bit_integer_codec (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  sbic_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output sbic_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [3:0]        csr_wdata
);
   import sbic_pkg::*;

`include "stop_bit_integer_codec_macros.svh"

   logic [1:0] width_code_ff;
   logic       value_signed_ff;
   logic [3:0] byte_limit_ff;
   cfg_type    cfg;

   logic       accept;
   logic       job_push;
   job_type    job_new;
   logic       queue_full;
   logic       queue_valid;
   job_type    queue_head;
   logic       job_take;

   // Configuration registers; writes to an unused index are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_code_ff   <= WIDTH_64;
         value_signed_ff <= 1'b1;
         byte_limit_ff   <= 4'(MAX_CODE_BYTES);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_WIDTH_CODE:   width_code_ff   <= csr_wdata[1:0];
            CSR_VALUE_SIGNED: value_signed_ff <= csr_wdata[0];
            CSR_BYTE_LIMIT:   byte_limit_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cfg.width_code   = width_code_ff;
   assign cfg.value_signed = value_signed_ff;
   assign cfg.byte_limit   = byte_limit_ff;

   // A beat is taken whenever the job queue has room, even if it will yield no job.
   assign req_full = queue_full;
   assign accept   = req_push && !queue_full;

   sbic_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req      (req_data),
      .cfg      (cfg),
      .job_push (job_push),
      .job      (job_new)
   );

   sbic_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (job_new),
      .full     (queue_full),
      .pop      (job_take),
      .valid    (queue_valid),
      .head     (queue_head)
   );

   sbic_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (queue_valid),
      .job       (queue_head),
      .job_take  (job_take),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   // The front end only writes a job into a queue slot that is free.
   `SBIC_ASSERT_NOW(a_no_queue_overflow, job_push, !queue_full, "job pushed into a full queue")

   // Only encode code bytes continue a run, and they never carry a status or the stop bit.
   `SBIC_ASSERT_NOW(a_mid_beat_is_code, !rsp_empty && !rsp_data.last,
      rsp_data.status == STATUS_OK && !rsp_data.code_byte_out[7],
      "a beat before the last one is not a plain code byte")

   // A code byte with the stop bit always closes its run.
   `SBIC_ASSERT_NOW(a_stop_bit_is_last, !rsp_empty && rsp_data.code_byte_out[7],
      rsp_data.last, "stop-bit code byte not marked last")

   // Taking a job needs a waiting one; taken from a full queue with no push beside it, it frees a slot.
   `SBIC_ASSERT_NEXT(a_take_has_job, job_take && !job_push && queue_full, !queue_full,
      "queue did not drain after a job was taken")

endmodule
